>>> hw/rtl/bfr_pkg.sv
// bfr_pkg: shared types, codes and sizes for the MSB-first bit field reader.
// No dependencies.
package bfr_pkg;

    localparam int DEF_MAX_FIELD_BITS = 32;
    localparam int DEF_BUFFER_BITS    = 40;

    localparam int OPCODE_W   = 2;
    localparam int BYTE_W     = 8;
    localparam int BITCNT_W   = 6;
    localparam int BYTECNT_W  = 3;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int HELD_W     = 6;
    localparam int CALC_W     = 7;

    localparam logic [OPCODE_W-1:0] OP_PUSH    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_READ    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_ALIGN   = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_READ_LE = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0]  opcode;
        logic [BYTE_W-1:0]    data_byte;
        logic [BITCNT_W-1:0]  bit_count;
        logic                 sign_extend;
        logic [BYTECNT_W-1:0] byte_count;
    } bfr_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
        logic [HELD_W-1:0]   bits_held;
    } bfr_result_t;

endpackage

>>> hw/rtl/bfr_exec.sv
// bfr_exec: bit buffer and held count registers with the combinational
// push / read / align / little-endian read logic. Depends on bfr_pkg.
module bfr_exec #(
    parameter int MAX_FIELD_BITS = bfr_pkg::DEF_MAX_FIELD_BITS,
    parameter int BUFFER_BITS    = bfr_pkg::DEF_BUFFER_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  bfr_pkg::bfr_item_t  item,
    output bfr_pkg::bfr_result_t result
);
    import bfr_pkg::*;

    localparam int CNT_W = $clog2(BUFFER_BITS + 1);
    localparam int CAP   = (BUFFER_BITS / 8) * 8;

    logic [BUFFER_BITS-1:0] buf_reg, buf_next;
    logic [CNT_W-1:0]       held_reg, held_next;

    logic [CALC_W-1:0]      held_c;
    logic [CALC_W-1:0]      aligned_c;
    logic [CALC_W-1:0]      nbits_c;
    logic [BITCNT_W-1:0]    nbits;
    logic [BYTECNT_W-1:0]   nbytes;
    logic [CALC_W-1:0]      le_bits_c;
    logic [CALC_W-1:0]      new_held_c;
    logic [VALUE_W-1:0]     field_mask;
    logic [VALUE_W-1:0]     field_raw;
    logic [VALUE_W-1:0]     field_val;
    logic [VALUE_W-1:0]     le_raw;
    logic [VALUE_W-1:0]     le_rev;
    logic [VALUE_W-1:0]     le_val;
    logic [4:0]             le_shift;
    logic [4:0]             sign_idx;
    logic                   update;

    assign held_c    = CALC_W'(held_reg);
    assign aligned_c = held_c & ~CALC_W'(7);

    assign nbits   = (item.bit_count > BITCNT_W'(MAX_FIELD_BITS))
                     ? BITCNT_W'(MAX_FIELD_BITS) : item.bit_count;
    assign nbits_c = CALC_W'(nbits);
    assign nbytes  = (item.byte_count > BYTECNT_W'(4)) ? BYTECNT_W'(4) : item.byte_count;
    assign le_bits_c = CALC_W'({nbytes, 3'b000});

    assign field_mask = ~({VALUE_W{1'b1}} << nbits);
    assign field_raw  = VALUE_W'(buf_reg >> (held_c - nbits_c)) & field_mask;
    assign sign_idx   = 5'(nbits - BITCNT_W'(1));

    always_comb
    begin
        field_val = field_raw;
        if (item.sign_extend && nbits < BITCNT_W'(32) && field_raw[sign_idx])
        begin
            field_val = field_raw | ~field_mask;
        end
    end

    assign le_raw = VALUE_W'(buf_reg >> (aligned_c - le_bits_c));

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            le_rev[8*k +: 8] = le_raw[8*(3-k) +: 8];
        end
    end

    assign le_shift = {2'(3'd4 - nbytes), 3'b000};
    assign le_val   = le_rev >> le_shift;

    always_comb
    begin
        result.value  = '0;
        result.status = ST_OK;
        update        = 1'b0;
        new_held_c    = held_c;
        buf_next      = buf_reg;
        case (item.opcode)
            OP_PUSH:
            begin
                if (held_c + CALC_W'(8) > CALC_W'(CAP))
                begin
                    result.status = ST_FULL;
                end
                else
                begin
                    update     = 1'b1;
                    new_held_c = held_c + CALC_W'(8);
                    buf_next   = {buf_reg[BUFFER_BITS-9:0], item.data_byte};
                end
            end
            OP_READ:
            begin
                if (nbits_c == '0)
                begin
                    result.status = ST_OK;
                end
                else if (nbits_c > held_c)
                begin
                    result.status = ST_SHORT;
                end
                else
                begin
                    update       = 1'b1;
                    new_held_c   = held_c - nbits_c;
                    result.value = field_val;
                end
            end
            OP_ALIGN:
            begin
                update     = 1'b1;
                new_held_c = aligned_c;
            end
            default:
            begin
                if (nbytes == '0)
                begin
                    result.status = ST_OK;
                end
                else if (le_bits_c > aligned_c)
                begin
                    result.status = ST_SHORT;
                end
                else
                begin
                    update       = 1'b1;
                    new_held_c   = aligned_c - le_bits_c;
                    result.value = le_val;
                end
            end
        endcase
        held_next = CNT_W'(new_held_c);
        buf_next  = buf_next & ~({BUFFER_BITS{1'b1}} << new_held_c);
        result.bits_held = HELD_W'(held_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg  <= '0;
            held_reg <= '0;
        end
        else if (fire && update)
        begin
            buf_reg  <= buf_next;
            held_reg <= held_next;
        end
    end

endmodule

>>> hw/rtl/msb_first_bit_field_reader.sv
// msb_first_bit_field_reader: MSB-first bitstream field extractor, top level.
// An accepted beat is captured in the item register; its result is loaded into
// the result register when the beat fires, which out_stall can hold off.
// Throughput: one beat per cycle while out_stall is low.
// Reset (rst_n, async, active low) empties the bit buffer and both stages.
// Depends on bfr_pkg and bfr_exec.
module msb_first_bit_field_reader #(
    parameter int MAX_FIELD_BITS = bfr_pkg::DEF_MAX_FIELD_BITS,
    parameter int BUFFER_BITS    = bfr_pkg::DEF_BUFFER_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [bfr_pkg::OPCODE_W-1:0]    opcode,
    input  logic [bfr_pkg::BYTE_W-1:0]      data_byte,
    input  logic [bfr_pkg::BITCNT_W-1:0]    bit_count,
    input  logic                            sign_extend,
    input  logic [bfr_pkg::BYTECNT_W-1:0]   byte_count,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [bfr_pkg::VALUE_W-1:0]     value,
    output logic [bfr_pkg::STATUS_W-1:0]    status,
    output logic [bfr_pkg::HELD_W-1:0]      bits_held
);
    import bfr_pkg::*;

    logic        in_valid_reg;
    bfr_item_t   item_reg;
    logic        out_valid_reg;
    bfr_result_t res_reg;
    bfr_result_t res_next;
    logic        out_load;
    logic        fire;
    logic        accept;

    assign out_load = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && out_load;
    assign in_stall = in_valid_reg && !out_load;
    assign accept   = in_valid && !in_stall;

    bfr_exec #(
        .MAX_FIELD_BITS (MAX_FIELD_BITS),
        .BUFFER_BITS    (BUFFER_BITS)
    ) u_exec (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_reg),
        .result (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= fire;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.opcode      <= opcode;
            item_reg.data_byte   <= data_byte;
            item_reg.bit_count   <= bit_count;
            item_reg.sign_extend <= sign_extend;
            item_reg.byte_count  <= byte_count;
        end
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = res_reg.value;
    assign status    = res_reg.status;
    assign bits_held = res_reg.bits_held;

endmodule
